// ===== hw/rtl/teq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants for the timed event queue
// Field widths, request codes and the records passed between the control
// and the row of storage cells.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int MAX_RUN      = 16;
  localparam int TIME_W       = 32;
  localparam int ID_W         = 16;
  localparam int REQ_W        = 2;
  localparam int COUNT_OUT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLR  = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] tm;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic              insert;
    logic              pop;
    logic              clear;
    logic [TIME_W-1:0] tm;
    logic [ID_W-1:0]   id;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/teq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// teq_cell: one slot of the sorted shift store
// Holds one entry. On insert it keeps its entry, takes its left neighbor's,
// or takes the new one; on pop it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module teq_cell import teq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cmd_t   cmd,
  input  wire entry_t prev_ent,     // left neighbor
  input  wire logic   prev_later,   // new entry goes at or left of the neighbor
  input  wire entry_t next_ent,     // right neighbor
  output entry_t      ent,
  output logic        later
);

  // An empty slot counts as later than any time; equal times stay in front.
  assign later = !ent.valid || (ent.tm > cmd.tm);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (cmd.clear) begin
      ent.valid <= 1'b0;
    end else if (cmd.insert && later) begin
      if (prev_later) begin
        ent <= prev_ent;
      end else begin
        ent <= '{valid: 1'b1, tm: cmd.tm, id: cmd.id};
      end
    end else if (cmd.pop) begin
      ent <= next_ent;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/teq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// teq_ctrl: request sequencer and result register
// Latches one request, drives insert, pop and clear into the cell row,
// walks a tick run one delivery per cycle while the output is free, holds each result until taken.
// ----------------------------------------------------------------------------
module teq_ctrl import teq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // event_id, expire_time, current_time
  input  wire logic [1:0]  s_tuser,   // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // out_event_id, entry_count, zero pad
  output logic             m_tlast,   // is_last
  output logic [1:0]       m_tuser,   // delivered, status
  input  wire entry_t      head,
  input  wire entry_t      second,
  output cmd_t             cmd
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RUN_W = $clog2(MAX_RUN + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state;
  logic [REQ_W-1:0]  req;
  logic [ID_W-1:0]   req_id;
  logic [TIME_W-1:0] req_exp;
  logic [TIME_W-1:0] req_now;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [RUN_W-1:0]  run;

  logic              out_free;
  logic              emit;
  logic              head_hit;
  logic              second_hit;
  logic              r_delivered;
  logic [ID_W-1:0]   r_id;
  logic              r_last;
  logic              r_status;

  assign s_tready   = (state == ST_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign head_hit   = head.valid && (head.tm <= req_now);
  assign second_hit = second.valid && (second.tm <= req_now);
  assign emit       = (state == ST_RUN) && out_free;

  always_comb begin
    cmd         = '{insert: 1'b0, pop: 1'b0, clear: 1'b0, tm: req_exp, id: req_id};
    count_next  = count;
    r_delivered = 1'b0;
    r_id        = '0;
    r_last      = 1'b1;
    r_status    = 1'b0;
    if (emit) begin
      case (req)
        REQ_ENQ: begin
          if (count == CNT_W'(CAPACITY)) begin
            r_status = 1'b1;
          end else begin
            cmd.insert = 1'b1;
            count_next = count + 1'b1;
          end
        end
        REQ_TICK: begin
          if (head_hit) begin
            cmd.pop     = 1'b1;
            count_next  = count - 1'b1;
            r_delivered = 1'b1;
            r_id        = head.id;
            r_last      = !(second_hit && (run < RUN_W'(MAX_RUN - 1)));
          end
        end
        REQ_CLR: begin
          cmd.clear  = 1'b1;
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      run      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (s_tvalid && s_tready) begin
        state <= ST_RUN;
        run   <= '0;
      end else if (emit) begin
        // stay in the run while another expired entry follows, up to MAX_RUN deliveries
        if (r_last) begin
          state <= ST_IDLE;
        end else begin
          run <= run + 1'b1;
        end
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req     <= s_tuser;
      req_id  <= s_tdata[15:0];
      req_exp <= s_tdata[47:16];
      req_now <= s_tdata[79:48];
    end
    if (emit) begin
      m_tdata <= {3'b000, COUNT_OUT_W'(count_next), r_id};
      m_tlast <= r_last;
      m_tuser <= {r_status, r_delivered};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/timed_event_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timed_event_queue: timer priority queue of pending events
// Up to CAPACITY (id, expiration) entries kept sorted in a row of cells.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. After an enqueue, a clear or an unknown
// request is accepted, the cell row inserts or clears and the acknowledgement
// is registered once the result output is free. A tick delivers n events (n at
// most MAX_RUN = 16), or one empty result if none has expired: the head cell is
// compared against the current time and popped once per cycle while the result
// output is not stalled, and the whole row shifts left with it. Expired entries
// beyond MAX_RUN stay for the next tick.
// ----------------------------------------------------------------------------
module timed_event_queue import teq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // [15:0] event_id, [47:16] expire_time,
                                      // [79:48] current_time
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [15:0] out_event_id, [20:16] entry_count,
                                      // [23:21] zero
  output logic             m_tlast,   // is_last
  output logic [1:0]       m_tuser    // [0] delivered, [1] status
);

  cmd_t   cmd;
  entry_t ents       [CAPACITY];
  logic   later_flags[CAPACITY];

  teq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .head     (ents[0]),
    .second   (ents[1]),
    .cmd      (cmd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_b;

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_b = 1'b0;
    end else begin : g_mid
      assign prev_e = ents[i-1];
      assign prev_b = later_flags[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_body
      assign next_e = ents[i+1];
    end

    teq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev_ent   (prev_e),
      .prev_later (prev_b),
      .next_ent   (next_e),
      .ent        (ents[i]),
      .later      (later_flags[i])
    );
  end

endmodule
`default_nettype wire

// ===== hw/rtl/teq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// teq_checker: port-level checks for the timed event queue
// Watches the stream ports and flags results that break the queue's rules.
// ----------------------------------------------------------------------------
module teq_checker import teq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,   // out_event_id, entry_count, zero pad
  input wire logic        m_tlast,   // is_last
  input wire logic [1:0]  m_tuser    // delivered, status
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // one transaction in flight: no accept right after an accept
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  a_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[0] && !m_tuser[1])
    else $error("non-final result without delivery");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1] && (m_tdata[20:16] != 5'd31 || CAPACITY > 31))
    else $error("delivery flagged as rejected");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CAPACITY > 31) || (32'(m_tdata[20:16]) <= 32'(CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind timed_event_queue teq_checker #(.CAPACITY(CAPACITY)) u_teq_checker (.*);
`default_nettype wire

// ===== verif/teq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// teq_scoreboard: scoreboard for the timed event queue
// Watches both stream channels. Each accepted request is run through a local
// sorted store that mirrors the queue, and the replies that it yields are
// compared field by field with the replies that the queue emits, in order.
// ----------------------------------------------------------------------------
module teq_scoreboard import teq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [79:0] s_tdata,   // [15:0] event_id, [47:16] expire_time,
                                      // [79:48] current_time
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,   // [15:0] out_event_id, [20:16] entry_count,
                                      // [23:21] zero
  input  wire logic        m_tlast,   // is_last
  input  wire logic [1:0]  m_tuser,   // [0] delivered, [1] status
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic               delivered;
    logic [ID_W-1:0]    id;
    logic               last;
    logic               status;
    logic [COUNT_OUT_W-1:0] count;
  } reply_t;

  logic [TIME_W-1:0] due_at [CAPACITY];
  logic [ID_W-1:0]   owner  [CAPACITY];
  int                held;
  reply_t            queue_replies [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    held        = 0;
  end

  function automatic reply_t make_reply(input logic dlv, input logic [ID_W-1:0] id,
                                        input logic last, input logic st);
    reply_t r;
    r.delivered = dlv;
    r.id        = id;
    r.last      = last;
    r.status    = st;
    r.count     = COUNT_OUT_W'(held);
    return r;
  endfunction

  // Append one expected reply at the tail.
  task automatic add_reply(input reply_t r);
    queue_replies = {queue_replies, r};
  endtask

  // Mirror one request on the local store and queue up its replies.
  task automatic apply_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] due, input logic [TIME_W-1:0] now);
    int pos;
    int n;
    int i;
    logic [ID_W-1:0] got;
    logic more;
    case (req)
      REQ_ENQ: begin
        if (held >= CAPACITY) begin
          add_reply(make_reply(1'b0, '0, 1'b1, 1'b1));
        end else begin
          // equal times keep insertion order: go past every entry due at or earlier
          pos = 0;
          while (pos < held && due_at[pos] <= due) pos++;
          for (i = held; i > pos; i--) begin
            due_at[i] = due_at[i-1];
            owner[i]  = owner[i-1];
          end
          due_at[pos] = due;
          owner[pos]  = id;
          held++;
          add_reply(make_reply(1'b0, '0, 1'b1, 1'b0));
        end
      end
      REQ_TICK: begin
        n = 0;
        while (n < MAX_RUN && held > 0 && due_at[0] <= now) begin
          got = owner[0];
          for (i = 0; i + 1 < held; i++) begin
            due_at[i] = due_at[i+1];
            owner[i]  = owner[i+1];
          end
          held--;
          n++;
          more = (n < MAX_RUN && held > 0 && due_at[0] <= now);
          add_reply(make_reply(1'b1, got, !more, 1'b0));
        end
        if (n == 0) begin
          add_reply(make_reply(1'b0, '0, 1'b1, 1'b0));
        end
      end
      REQ_CLR: begin
        held = 0;
        add_reply(make_reply(1'b0, '0, 1'b1, 1'b0));
      end
      default: begin
        add_reply(make_reply(1'b0, '0, 1'b1, 1'b0));
      end
    endcase
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      held = 0;
      queue_replies.delete();
    end else begin
      // take the request first so a same-edge reply still lines up in order
      if (s_tvalid && s_tready) begin
        apply_request(s_tuser, s_tdata[15:0], s_tdata[47:16], s_tdata[79:48]);
      end
      if (m_tvalid && m_tready) begin
        if (queue_replies.size() == 0) begin
          $error("reply transaction with nothing pending: id %0d count %0d",
                 m_tdata[15:0], m_tdata[20:16]);
          mismatches++;
        end else begin
          want = queue_replies.pop_front();
          compare_field("delivered", want.delivered, m_tuser[0]);
          compare_field("out_event_id", want.id, m_tdata[15:0]);
          compare_field("is_last", want.last, m_tlast);
          compare_field("status", want.status, m_tuser[1]);
          compare_field("entry_count", want.count, m_tdata[20:16]);
          compare_field("tdata padding", 0, m_tdata[23:21]);
        end
      end
    end
    outstanding = queue_replies.size();
  end

endmodule
`default_nettype wire

// ===== verif/timed_event_queue_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timed_event_queue_tb: stimulus and verdict for the timed event queue
// Drives directed requests (empty ticks, equal expirations, a full store,
// a maximal delivery run, clears and unknown requests) and then random
// traffic around a running clock, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module timed_event_queue_tb;
  import teq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_BAD = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  int          mismatches;
  int          outstanding;
  int          cycles = 0;
  logic        no_idle = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  timed_event_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  teq_scoreboard chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timed_event_queue_tb: errors");
      $finish;
    end
  end

  // Hold tvalid across back-to-back transactions; drop it only for a gap.
  task automatic send(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                      input logic [TIME_W-1:0] due, input logic [TIME_W-1:0] now);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {now, due, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_event(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] due);
    send(REQ_ENQ, id, due, $urandom);
  endtask

  task automatic tick_at(input logic [TIME_W-1:0] now);
    send(REQ_TICK, 16'($urandom), $urandom, now);
  endtask

  task automatic issue(input logic [REQ_W-1:0] req);
    send(req, 16'($urandom), $urandom, $urandom);
  endtask

  // Result side: random backpressure per reply transaction.
  initial begin
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [TIME_W-1:0] clock_now;
    logic [TIME_W-1:0] last_due;
    logic [TIME_W-1:0] due;
    int pick;
    int k;
    int j;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty store, unknown request, extremes, equal expirations
    tick_at(32'd0);
    issue(REQ_CLR);
    issue(REQ_BAD);
    push_event(16'hFFFF, 32'hFFFF_FFFF);
    push_event(16'h0000, 32'd0);
    push_event(16'h1234, 32'd100);
    push_event(16'h5678, 32'd100);
    tick_at(32'd99);
    tick_at(32'd100);
    // fill the store, overflow it, then drain it in one run
    for (j = 0; j < CAPACITY_DEF - 1; j++) begin
      push_event(16'($urandom), $urandom_range(200, 206));
    end
    push_event(16'hABCD, 32'd1);
    issue(REQ_BAD);
    tick_at(32'hFFFF_FFFF);
    push_event(16'h00FF, 32'd5);
    issue(REQ_CLR);

    // random: mostly enqueues and ticks around an advancing clock
    clock_now = $urandom_range(0, 1000);
    last_due  = clock_now;
    for (k = 0; k < 80; k++) begin
      if (k % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        case ($urandom_range(0, 9))
          0:       due = $urandom;
          1:       due = 32'd0;
          2:       due = 32'hFFFF_FFFF;
          3:       due = last_due;
          default: due = clock_now + $urandom_range(0, 300);
        endcase
        last_due = due;
        push_event(16'($urandom), due);
      end else if (pick < 85) begin
        clock_now = clock_now + $urandom_range(0, 120);
        tick_at(($urandom_range(0, 11) == 0) ? $urandom : clock_now);
      end else if (pick < 89) begin
        issue(REQ_CLR);
      end else if (pick < 97) begin
        issue(REQ_BAD);
      end else begin
        // burst past capacity to reach the full store
        for (j = 0; j < 18; j++) begin
          push_event(16'($urandom), clock_now + $urandom_range(0, 40));
        end
      end
    end

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("timed_event_queue_tb: clean");
    end else begin
      $display("timed_event_queue_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
